FILE: src/afsp_pkg.sv
// Shared constants and types for the API frame sensor parser.
`default_nettype none
package afsp_pkg;

   localparam logic [7:0] StartByte  = 8'h7E;
   localparam logic [7:0] LenHigh    = 8'h00;
   localparam logic [7:0] LenLow     = 8'h14;
   localparam logic [7:0] GoodSum    = 8'hFF;

   localparam int         BodyBytes  = 21;
   localparam int         WordCount  = 5;
   localparam int         PosWidth   = $clog2(BodyBytes);
   localparam int         WordIdxW   = $clog2(WordCount);

   localparam logic [PosWidth-1:0] LastPos      = PosWidth'(BodyBytes - 1);
   localparam logic [PosWidth-1:0] FirstWordPos = PosWidth'(10);
   localparam logic [PosWidth-1:0] EndWordPos   = PosWidth'(10 + 2 * WordCount);

   localparam int         DefQueueDepth = 4;

   // One body byte handed from front to back, with its place in the body.
   typedef struct packed {
      logic [7:0]          data;
      logic [PosWidth-1:0] pos;
   } body_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

FILE: src/afsp_front.sv
// Front end: header hunt and body byte tagging.
`default_nettype none
module afsp_front
   import afsp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire queue_status_type q_status,
   output logic                  push,
   output body_item_type         push_item,
   output logic [PosWidth-1:0]   body_count
);

   localparam logic [1:0] PhHunt = 2'd0;
   localparam logic [1:0] PhLen0 = 2'd1;
   localparam logic [1:0] PhLen1 = 2'd2;
   localparam logic [1:0] PhBody = 2'd3;

   logic [1:0]          phase_ff, phase_in;
   logic [PosWidth-1:0] count_ff, count_in;
   logic                accept;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (phase_ff == PhBody);
   assign push_item  = '{data: req_tdata, pos: count_ff};
   assign body_count = count_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         unique case (phase_ff)
            PhHunt: begin
               if (req_tdata == StartByte) phase_in = PhLen0;
            end
            PhLen0: begin
               phase_in = (req_tdata == LenHigh) ? PhLen1 : PhHunt;
            end
            PhLen1: begin
               // a wrong length byte is dropped, not rechecked as a start byte
               phase_in = (req_tdata == LenLow) ? PhBody : PhHunt;
               count_in = '0;
            end
            PhBody: begin
               if (count_ff >= LastPos) begin
                  phase_in = PhHunt;
                  count_in = '0;
               end else begin
                  count_in = count_ff + PosWidth'(1);
               end
            end
            default: phase_in = PhHunt;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhHunt;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/afsp_queue.sv
// Small register FIFO between front and back.
`default_nettype none
module afsp_queue
   import afsp_pkg::*;
#(
   parameter int Depth = DefQueueDepth
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire body_item_type push_item,
   input  wire logic          pop,
   output body_item_type      head,
   output queue_status_type   status
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   body_item_type         slot_ff [Depth];
   logic [AW-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]         fill_ff, fill_in;

   assign status.full  = (fill_ff == CW'(Depth));
   assign status.empty = (fill_ff == '0);
   assign head         = slot_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) wr_in = (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + AW'(1);
      if (pop)  rd_in = (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + AW'(1);
      if (push && !pop)      fill_in = fill_ff + CW'(1);
      else if (pop && !push) fill_in = fill_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/afsp_back.sv
// Back end: checksum, word capture and result register.
`default_nettype none
module afsp_back
   import afsp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire body_item_type    head,
   input  wire queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [79:0]           rsp_tdata
);

   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          hi_ff [WordCount];
   logic [7:0]          lo_ff [WordCount];
   logic                valid_ff, valid_in;
   logic [79:0]         data_ff, data_in;
   logic [PosWidth-1:0] rel;
   logic [WordIdxW-1:0] widx;
   logic                in_words, last;

   assign pop      = !q_status.empty && (!valid_ff || rsp_tready);
   assign last     = (head.pos >= LastPos);
   assign in_words = (head.pos >= FirstWordPos) && (head.pos < EndWordPos);
   assign rel      = head.pos - FirstWordPos;
   assign widx     = rel[WordIdxW:1];

   // running sum restarts on the first body byte of a frame
   assign sum_in = ((head.pos == '0) ? 8'h00 : sum_ff) + head.data;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pop && last && (sum_in == GoodSum)) begin
         valid_in = 1'b1;
         for (int k = 0; k < WordCount; k++) begin
            data_in[16*k +: 16] = {hi_ff[k], lo_ff[k]};
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) sum_ff <= sum_in;
      if (pop && in_words && !last) begin
         if (rel[0]) lo_ff[widx] <= head.data;
         else        hi_ff[widx] <= head.data;
      end
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule
`default_nettype wire

FILE: src/api_frame_sensor_parser.sv
// Top level of the API frame sensor parser.
// Takes one serial byte per transfer on req_ and looks for frames of start
// byte 0x7E, length 0x00 0x14, 20 data bytes and a checksum byte. A frame
// whose body sums to 0xFF gives one transfer on rsp_ with five 16-bit words
// from data bytes 10..19; a bad frame gives nothing. The header tracker
// accepts a byte per clock whenever the body queue (QueueDepth entries) has
// room, and the checksum unit drains one queued byte per clock while its
// result register is free or being taken. A good checksum byte passes
// through the body queue and then sets the result register behind rsp_tvalid.
`default_nettype none
module api_frame_sensor_parser
   import afsp_pkg::*;
#(
   parameter int QueueDepth = DefQueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata    // accel_z, accel_y, accel_x, emg_first, emg_second
);

   queue_status_type    q_status;
   body_item_type       push_item, head;
   logic                push, pop;
   logic [PosWidth-1:0] body_count;

   afsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item),
      .body_count (body_count)
   );

   afsp_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   afsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("push into full body queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from empty body queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      body_count <= LastPos)
      else $error("body count past checksum position");

   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pop && (head.pos == LastPos)))
      else $error("result without a checksum byte");

endmodule
`default_nettype wire

FILE: bench/tb_api_frame_sensor_parser.sv
// Self-checking testbench for the API frame sensor parser: frame stimulus, byte-level predictor.
`default_nettype none
module tb_api_frame_sensor_parser
   import afsp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      SEEK_START,
      SEEK_LEN_HIGH,
      SEEK_LEN_LOW,
      IN_BODY
   } parse_state_type;

   // accel_z sits in the lowest bits of rsp_tdata
   typedef struct packed {
      logic [15:0] emg_second;
      logic [15:0] emg_first;
      logic [15:0] accel_x;
      logic [15:0] accel_y;
      logic [15:0] accel_z;
   } sensor_sample_type;

   class sensor_frame_predictor;
      parse_state_type   state;
      logic [4:0]        body_pos;
      logic [7:0]        body_sum;
      logic [15:0]       words [WordCount];
      sensor_sample_type expected_samples [$];
      int                mismatches;
      int                failures;

      function new();
         state      = SEEK_START;
         body_pos   = '0;
         body_sum   = '0;
         mismatches = 0;
         failures   = 0;
         foreach (words[i]) words[i] = '0;
      endfunction

      // Advance the parse by one accepted byte; queue a sample on a good checksum.
      function void take_byte(logic [7:0] b);
         int                rel;
         sensor_sample_type s;
         case (state)
            SEEK_START: begin
               if (b == StartByte) state = SEEK_LEN_HIGH;
            end
            SEEK_LEN_HIGH: begin
               if (b == LenHigh) state = SEEK_LEN_LOW;
               else state = SEEK_START;
            end
            SEEK_LEN_LOW: begin
               if (b == LenLow) begin
                  state    = IN_BODY;
                  body_pos = '0;
                  body_sum = '0;
               end else begin
                  state = SEEK_START;
               end
            end
            default: begin
               body_sum = body_sum + b;
               if (body_pos >= BodyBytes - 1) begin
                  if (body_sum == GoodSum) begin
                     s.accel_z    = words[0];
                     s.accel_y    = words[1];
                     s.accel_x    = words[2];
                     s.emg_first  = words[3];
                     s.emg_second = words[4];
                     expected_samples.push_back(s);
                  end
                  state    = SEEK_START;
                  body_pos = '0;
                  body_sum = '0;
               end else begin
                  if (body_pos >= FirstWordPos && body_pos < EndWordPos) begin
                     rel = int'(body_pos) - int'(FirstWordPos);
                     if (rel[0] == 1'b0) words[rel >> 1] = {b, 8'h00};
                     else words[rel >> 1][7:0] = b;
                  end
                  body_pos = body_pos + 1'b1;
               end
            end
         endcase
      endfunction

      function void check_sample(logic [79:0] d);
         sensor_sample_type got;
         sensor_sample_type want;
         got = sensor_sample_type'(d);
         if (expected_samples.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result %h", $realtime, d);
            return;
         end
         want = expected_samples.pop_front();
         if (got.accel_z !== want.accel_z || got.accel_y !== want.accel_y ||
             got.accel_x !== want.accel_x || got.emg_first !== want.emg_first ||
             got.emg_second !== want.emg_second) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result mismatch z/y/x/e1/e2 exp %h %h %h %h %h got %h %h %h %h %h",
                        $realtime, want.accel_z, want.accel_y, want.accel_x,
                        want.emg_first, want.emg_second, got.accel_z, got.accel_y,
                        got.accel_x, got.emg_first, got.emg_second);
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;           // accel_z, accel_y, accel_x, emg_first, emg_second

   sensor_frame_predictor predictor;

   int   burst_left = 0;
   int   frame_bytes = 0;
   bit   hold_req = 1'b0;
   bit   hold_active = 1'b0;
   logic [7:0] frame_data [20];

   api_frame_sensor_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && predictor != null) begin
         if (rsp_tvalid && rsp_tready) predictor.check_sample(rsp_tdata);
         if (req_tvalid && req_tready) predictor.take_byte(req_tdata);
      end
   end

   // Offer one byte, idling between bursts; returns at the edge of the transfer.
   task automatic put_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
         if ($urandom_range(0, 3) == 0 || hold_req || hold_active) gap = 0;
         else gap = $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frame_bytes++;
   endtask

   task automatic send_frame(input bit good_sum);
      logic [7:0] sum;
      logic [7:0] check;
      sum = 8'h00;
      put_byte(StartByte);
      put_byte(LenHigh);
      put_byte(LenLow);
      foreach (frame_data[i]) begin
         put_byte(frame_data[i]);
         sum = sum + frame_data[i];
      end
      check = GoodSum - sum;
      if (!good_sum) check = check + 8'($urandom_range(1, 255));
      put_byte(check);
   endtask

   task automatic fill_frame(input int kind);
      foreach (frame_data[i]) begin
         case (kind)
            0: frame_data[i] = 8'h00;
            1: frame_data[i] = 8'hFF;
            default: frame_data[i] = 8'($urandom_range(0, 255));
         endcase
      end
   endtask

   // Receiver: stall pattern is redrawn at random; one long hold-off on request.
   initial begin
      int mode;
      int span;
      int step;
      span = 0;
      mode = 0;
      step = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req    = 1'b0;
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_active = 1'b0;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            step = 0;
         end
         span--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (step % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
         step++;
      end
   end

   initial begin
      #5_000_000;
      $display("tb_api_frame_sensor_parser: errors");
      $finish;
   end

   initial begin
      int frames;
      int pick;
      int n;
      predictor = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // words all ones
      fill_frame(0);
      for (int i = 10; i < 20; i++) frame_data[i] = 8'hFF;
      send_frame(1'b1);
      // start byte as first length byte is dropped, not taken as a new start
      put_byte(StartByte);
      put_byte(StartByte);
      put_byte(LenHigh);
      put_byte(LenLow);
      // start byte inside the body and in the last word byte, other word bytes zero
      fill_frame(0);
      frame_data[3]  = StartByte;
      frame_data[19] = StartByte;
      send_frame(1'b1);
      // wrong second length byte
      put_byte(StartByte);
      put_byte(LenHigh);
      put_byte(StartByte);
      put_byte(LenHigh);
      put_byte(LenLow);
      foreach (frame_data[i]) frame_data[i] = 8'(i * 37 + 5);
      send_frame(1'b1);
      // bad checksum
      send_frame(1'b0);
      fill_frame(1);
      send_frame(1'b1);

      frames = 0;
      while (frame_bytes < 1600) begin
         if (frames == 20) begin
            // long receiver hold-off while frames keep coming back to back
            hold_req = 1'b1;
            while (hold_req || hold_active) begin
               fill_frame(2);
               send_frame(1'b1);
            end
         end
         frames++;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = $urandom_range(0, 9);
            fill_frame(n < 2 ? n : 2);
            send_frame(1'b1);
         end else if (pick < 80) begin
            fill_frame(2);
            send_frame(1'b0);
         end else if (pick < 86) begin
            // broken header
            put_byte(StartByte);
            if ($urandom_range(0, 1) == 0) begin
               put_byte(8'($urandom_range(1, 255)));
            end else begin
               put_byte(LenHigh);
               n = $urandom_range(0, 255);
               if (n == LenLow) n = StartByte;
               put_byte(8'(n));
            end
         end else if (pick < 92) begin
            // frame cut short; following bytes land in its body
            put_byte(StartByte);
            put_byte(LenHigh);
            put_byte(LenLow);
            n = $urandom_range(0, 19);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) put_byte(StartByte);
               else put_byte(8'($urandom_range(0, 255)));
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (predictor.failures == 0 && predictor.pending() == 0) begin
         $display("tb_api_frame_sensor_parser: clean");
      end else begin
         $display("tb_api_frame_sensor_parser: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
src/afsp_pkg.sv
src/afsp_front.sv
src/afsp_queue.sv
src/afsp_back.sv
src/api_frame_sensor_parser.sv
bench/tb_api_frame_sensor_parser.sv
